[src/assert_macros.svh]
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked property, off while reset is asserted
`define TUN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// checked property, also during reset
`define TUN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TUN_ASSERT(lbl, clk, rst_n, prop)
`define TUN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/tun_pkg.sv]
`default_nettype none
package tun_pkg;

  // per item side flags carried along the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tun_flags_t;

  // stages ahead of the root cells: diff, cross, combine, partials, square, sum
  localparam int unsigned FrontStages = 6;

endpackage
`default_nettype wire

[src/tun_front.sv]
`default_nettype none
module tun_front #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned OUT_FRAC_BITS = 14,
  parameter int unsigned XW            = 104,
  parameter int unsigned AW            = 72
) (
  input  wire logic                          clk_i,
  input  wire logic [tun_pkg::FrontStages-1:0] ld_i,
  input  wire logic [2:0][COORD_WIDTH-1:0]   pa_i,
  input  wire logic [2:0][COORD_WIDTH-1:0]   pb_i,
  input  wire logic [2:0][COORD_WIDTH-1:0]   pc_i,
  output logic      [2:0][XW-1:0]            e_o,
  output logic      [AW-1:0]                 s_o,
  output tun_pkg::tun_flags_t                flags_o
);
  localparam int unsigned C  = COORD_WIDTH;
  localparam int unsigned D  = C + 1;
  localparam int unsigned PW = 2 * D;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned H  = (NW + 1) / 2;
  localparam int unsigned HW = NW - H;
  localparam int unsigned SW = 2 * NW;
  localparam int unsigned TS = 2 * OUT_FRAC_BITS + 2;

  logic signed [2:0][D-1:0]  u_q, v_q;
  logic signed [5:0][PW-1:0] pr_q;
  logic        [2:0][NW-1:0] mag_q;
  logic        [2:0]         neg3_q, neg4_q, neg5_q;
  logic        [2:0][2*HW-1:0] hh_q;
  logic        [2:0][HW+H-1:0] hl_q;
  logic        [2:0][2*H-1:0]  ll_q;
  logic        [2:0][SW-1:0] sq_q;
  logic        [2:0][XW-1:0] e_q;
  logic        [AW-1:0]      s_q;
  tun_pkg::tun_flags_t       flags_q;

  logic signed [2:0][NW-1:0] n_d;
  logic        [AW-1:0]      s_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = '0;
    end
    n_d[0] = $signed({pr_q[0][PW-1], pr_q[0]}) - $signed({pr_q[1][PW-1], pr_q[1]});
    n_d[1] = $signed({pr_q[2][PW-1], pr_q[2]}) - $signed({pr_q[3][PW-1], pr_q[3]});
    n_d[2] = $signed({pr_q[4][PW-1], pr_q[4]}) - $signed({pr_q[5][PW-1], pr_q[5]});
    s_d = AW'(sq_q[0]) + AW'(sq_q[1]) + AW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= $signed({pb_i[i][C-1], pb_i[i]}) - $signed({pa_i[i][C-1], pa_i[i]});
        v_q[i] <= $signed({pc_i[i][C-1], pc_i[i]}) - $signed({pa_i[i][C-1], pa_i[i]});
      end
    end
    // element selects drop the sign, so restore it for the products
    if (ld_i[1]) begin
      pr_q[0] <= PW'($signed(u_q[1]) * $signed(v_q[2]));
      pr_q[1] <= PW'($signed(u_q[2]) * $signed(v_q[1]));
      pr_q[2] <= PW'($signed(u_q[2]) * $signed(v_q[0]));
      pr_q[3] <= PW'($signed(u_q[0]) * $signed(v_q[2]));
      pr_q[4] <= PW'($signed(u_q[0]) * $signed(v_q[1]));
      pr_q[5] <= PW'($signed(u_q[1]) * $signed(v_q[0]));
    end
    if (ld_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= n_d[i][NW-1];
        mag_q[i]  <= n_d[i][NW-1] ? NW'(-n_d[i]) : NW'(n_d[i]);
      end
    end
    // square split in halves to keep each multiplier narrow
    if (ld_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= (2*HW)'(mag_q[i][NW-1:H]) * (2*HW)'(mag_q[i][NW-1:H]);
        hl_q[i] <= (HW+H)'(mag_q[i][NW-1:H]) * (HW+H)'(mag_q[i][H-1:0]);
        ll_q[i] <= (2*H)'(mag_q[i][H-1:0]) * (2*H)'(mag_q[i][H-1:0]);
      end
      neg4_q <= neg3_q;
    end
    if (ld_i[4]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SW'(hh_q[i]) << (2*H)) + (SW'(hl_q[i]) << (H+1)) + SW'(ll_q[i]);
      end
      neg5_q <= neg4_q;
    end
    if (ld_i[5]) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= XW'(sq_q[i]) << TS;
      end
      s_q           <= s_d;
      flags_q.neg   <= neg5_q;
      flags_q.degen <= (s_d == '0);
    end
  end

  assign e_o     = e_q;
  assign s_o     = s_q;
  assign flags_o = flags_q;
endmodule
`default_nettype wire

[src/tun_cell.sv]
`default_nettype none
// one bit of r = isqrt(T / s) per lane, residual e = T - r*r*s, p = r*s
module tun_cell #(
  parameter int unsigned K  = 0,
  parameter int unsigned XW = 104,
  parameter int unsigned AW = 72,
  parameter int unsigned RW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                ld_i,
  input  wire logic [2:0][XW-1:0]  e_i,
  input  wire logic [2:0][XW-1:0]  p_i,
  input  wire logic [2:0][RW-1:0]  r_i,
  input  wire logic [AW-1:0]       s_i,
  input  wire tun_pkg::tun_flags_t flags_i,
  output logic      [2:0][XW-1:0]  e_o,
  output logic      [2:0][XW-1:0]  p_o,
  output logic      [2:0][RW-1:0]  r_o,
  output logic      [AW-1:0]       s_o,
  output tun_pkg::tun_flags_t      flags_o
);
  logic [2:0][XW-1:0] e_d, p_d, e_q, p_q;
  logic [2:0][RW-1:0] r_d, r_q;
  logic [2:0][XW-1:0] sub;
  logic [AW-1:0]      s_q;
  tun_pkg::tun_flags_t flags_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sub[i] = (p_i[i] << (K + 1)) + (XW'(s_i) << (2 * K));
      e_d[i] = e_i[i];
      p_d[i] = p_i[i];
      r_d[i] = r_i[i];
      if (sub[i] <= e_i[i]) begin
        e_d[i] = e_i[i] - sub[i];
        p_d[i] = p_i[i] + (XW'(s_i) << K);
        r_d[i] = r_i[i] | (RW'(1) << K);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      e_q     <= e_d;
      p_q     <= p_d;
      r_q     <= r_d;
      s_q     <= s_i;
      flags_q <= flags_i;
    end
  end

  assign e_o     = e_q;
  assign p_o     = p_q;
  assign r_o     = r_q;
  assign s_o     = s_q;
  assign flags_o = flags_q;
endmodule
`default_nettype wire

[src/triangle_unit_normal.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | a_*_i, b_*_i, c_*_i
// out     | output    | out_valid_o/out_stall_i | unit_*_o, degenerate_o
// one item per cycle while out_stall_i is low; an item passes the front stages, one root
// cell per result bit and then the output register
// reset clears only the stage valid bits, no data
// a stage loads whenever it is empty or the stage after it moves, so bubbles close up
// under a stall; in_stall_o rises only when every stage holds an item
`default_nettype none
`include "assert_macros.svh"
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [COORD_WIDTH-1:0]   a_x_i,
  input  wire logic [COORD_WIDTH-1:0]   a_y_i,
  input  wire logic [COORD_WIDTH-1:0]   a_z_i,
  input  wire logic [COORD_WIDTH-1:0]   b_x_i,
  input  wire logic [COORD_WIDTH-1:0]   b_y_i,
  input  wire logic [COORD_WIDTH-1:0]   b_z_i,
  input  wire logic [COORD_WIDTH-1:0]   c_x_i,
  input  wire logic [COORD_WIDTH-1:0]   c_y_i,
  input  wire logic [COORD_WIDTH-1:0]   c_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [OUT_FRAC_BITS+1:0]      unit_x_o,
  output logic [OUT_FRAC_BITS+1:0]      unit_y_o,
  output logic [OUT_FRAC_BITS+1:0]      unit_z_o,
  output logic                          degenerate_o
);
  localparam int unsigned F  = OUT_FRAC_BITS;
  localparam int unsigned OW = F + 2;
  localparam int unsigned NW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int unsigned AW = 2 * NW + 2;
  localparam int unsigned XW = AW + 2 * F + 4;
  localparam int unsigned RW = F + 2;
  localparam int unsigned NC = F + 2;
  localparam int unsigned FS = tun_pkg::FrontStages;
  localparam int unsigned NS = FS + NC + 1;
  localparam logic signed [OW-1:0] UnitOne = OW'(1) << F;

  logic [NS-1:0] v_q, rdy, vin, ld;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end
  assign vin = {v_q[NS-2:0], in_valid_i};
  assign ld  = rdy & vin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= vin[i];
        end
      end
    end
  end

  // front: edges, cross product, squares, length squared
  logic [NC:0][2:0][XW-1:0] e_w, p_w;
  logic [NC:0][2:0][RW-1:0] r_w;
  logic [NC:0][AW-1:0]      s_w;
  tun_pkg::tun_flags_t      flags_w [NC+1];

  tun_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_FRAC_BITS(OUT_FRAC_BITS),
    .XW           (XW),
    .AW           (AW)
  ) u_front (
    .clk_i  (clk_i),
    .ld_i   (ld[FS-1:0]),
    .pa_i   ({a_z_i, a_y_i, a_x_i}),
    .pb_i   ({b_z_i, b_y_i, b_x_i}),
    .pc_i   ({c_z_i, c_y_i, c_x_i}),
    .e_o    (e_w[0]),
    .s_o    (s_w[0]),
    .flags_o(flags_w[0])
  );
  assign p_w[0] = '0;
  assign r_w[0] = '0;

  // root cells, most significant result bit first
  for (genvar g = 0; g < NC; g++) begin : g_cell
    tun_cell #(
      .K (NC - 1 - g),
      .XW(XW),
      .AW(AW),
      .RW(RW)
    ) u_cell (
      .clk_i  (clk_i),
      .ld_i   (ld[FS+g]),
      .e_i    (e_w[g]),
      .p_i    (p_w[g]),
      .r_i    (r_w[g]),
      .s_i    (s_w[g]),
      .flags_i(flags_w[g]),
      .e_o    (e_w[g+1]),
      .p_o    (p_w[g+1]),
      .r_o    (r_w[g+1]),
      .s_o    (s_w[g+1]),
      .flags_o(flags_w[g+1])
    );
  end

  // round: q = (r + 1) / 2, then sign; zero for a degenerate triangle
  logic [2:0][OW-1:0] unit_d, unit_q;
  logic [2:0][RW:0]   rp1;
  logic               degen_q;
  tun_pkg::tun_flags_t fl;

  always_comb begin
    fl = flags_w[NC];
    for (int i = 0; i < 3; i++) begin
      rp1[i] = {1'b0, r_w[NC][i]} + (RW+1)'(1);
      if (fl.degen) begin
        unit_d[i] = '0;
      end else if (fl.neg[i]) begin
        unit_d[i] = -OW'(rp1[i][RW:1]);
      end else begin
        unit_d[i] = OW'(rp1[i][RW:1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      unit_q  <= unit_d;
      degen_q <= fl.degen;
    end
  end

  assign in_stall_o   = !rdy[0];
  assign out_valid_o  = v_q[NS-1];
  assign unit_x_o     = unit_q[0];
  assign unit_y_o     = unit_q[1];
  assign unit_z_o     = unit_q[2];
  assign degenerate_o = degen_q;

  `TUN_ASSERT_ALWAYS(a_stall_full, clk_i, in_stall_o |-> (&v_q))
  `TUN_ASSERT(a_degen_zero, clk_i, rst_ni, (out_valid_o && degenerate_o) |-> (unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0))
  `TUN_ASSERT(a_unit_range, clk_i, rst_ni, out_valid_o |-> ($signed(unit_x_o) <= UnitOne && $signed(unit_x_o) >= -UnitOne))
  `TUN_ASSERT(a_out_moves, clk_i, rst_ni, (v_q[NS-2] && !out_valid_o) |=> out_valid_o)
endmodule
`default_nettype wire
